/* rtl/csd_pkg.sv */
package csd_pkg;

	// default sizes of the directory
	localparam int CSD_MAX_USERS  = 32;
	localparam int CSD_MAX_CHUNKS = 64;

	// field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int UID_W    = 6;
	localparam int CID_W    = 7;
	localparam int MASK_W   = 64;
	localparam int STATUS_W = 2;

	// chunk count register after reset
	localparam logic [CID_W-1:0] NUM_CHUNKS_RST = 7'd64;

	// operation codes
	localparam logic [OP_W-1:0] OP_JOIN    = 2'd0;
	localparam logic [OP_W-1:0] OP_LEAVE   = 2'd1;
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_JOIN_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OWNER   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

endpackage

/* rtl/csd_ram.sv */
module csd_ram
	import csd_pkg::*;
#(
	parameter int WIDTH = CSD_MAX_CHUNKS,
	parameter int DEPTH = CSD_MAX_USERS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/chunk_sharer_directory_top.sv */
// Chunk ownership directory. A word is taken when start is high and busy is low; results come
// out on status/result_user/is_last, each shown for exactly one cycle under result_valid, and
// the receiver cannot stall them. Leave, op 3 and a request with a bad user or chunk are done
// in the accept cycle (the bad request answers with a single no-owner word). Join walks the
// user table one id per cycle until a free id is found, or answers full after the last id.
// A valid request scans every user's ownership row through the single read port of the row
// RAM, one row per cycle; owners stream out as the scan goes, ascending, at most one per
// cycle. Each result is registered and shows up in the cycle after the cycle that made it.
// The user must write the chunk count register (cfg_valid/cfg_data) only while the block is
// idle; the block does not enforce this. The RAM needs no clearing.
module chunk_sharer_directory_top
	import csd_pkg::*;
#(
	parameter int MAX_USERS  = CSD_MAX_USERS,
	parameter int MAX_CHUNKS = CSD_MAX_CHUNKS
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     op,
	input  logic [UID_W-1:0]    user_id,
	input  logic [CID_W-1:0]    chunk_id,
	input  logic [MASK_W-1:0]   owned_mask,
	// result channel
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [UID_W-1:0]    result_user,
	output logic                is_last,
	// chunk count register
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CID_W-1:0]    cfg_data
);

	localparam int UIDX_W = $clog2(MAX_USERS);
	localparam int CIDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam logic [UIDX_W-1:0] LAST_IDX = UIDX_W'(MAX_USERS - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_JOIN  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [MAX_USERS-1:0]  user_active_q;
	logic [CID_W-1:0]      num_chunks_q;
	logic [UIDX_W-1:0]     idx_q, idx_d;
	logic [UIDX_W-1:0]     idx_s1;
	logic                  scan_vld_s1;
	logic                  pend_vld_q, pend_vld_d;
	logic [UIDX_W-1:0]     pend_q, pend_d;
	logic [UIDX_W-1:0]     slot_q;
	logic [CIDX_W-1:0]     bit_idx_q;
	logic [MAX_CHUNKS-1:0] join_row_q;
	logic [MAX_CHUNKS-1:0] row_q;

	logic                  res_vld_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [UID_W-1:0]      res_user_q;
	logic                  res_last_q;

	logic                  accept;
	logic [CID_W-1:0]      nc_eff;
	logic [MAX_CHUNKS-1:0] chunk_mask;
	logic [UIDX_W-1:0]     slot_in;
	logic                  uid_ok;
	logic                  cid_ok;
	logic                  hit;

	logic                  emit;
	logic [STATUS_W-1:0]   e_status;
	logic [UID_W-1:0]      e_user;
	logic                  e_last;
	logic                  act_set, act_clr;
	logic [UIDX_W-1:0]     act_idx;
	logic                  ram_we, ram_re;
	logic [UIDX_W-1:0]     ram_waddr;
	logic [MAX_CHUNKS-1:0] ram_wdata;
	logic [MAX_CHUNKS-1:0] ram_rdata;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// chunks in use: min(num_chunks, MAX_CHUNKS)
	assign nc_eff = (num_chunks_q > CID_W'(MAX_CHUNKS)) ? CID_W'(MAX_CHUNKS) : num_chunks_q;

	always_comb begin
		for (int k = 0; k < MAX_CHUNKS; k++) begin
			chunk_mask[k] = (CID_W'(k) < nc_eff);
		end
	end

	// command checks at accept
	assign slot_in = UIDX_W'(user_id - UID_W'(1));
	assign uid_ok  = (user_id != '0) && ({1'b0, user_id} <= 7'(MAX_USERS))
		&& user_active_q[slot_in];
	assign cid_ok  = (chunk_id != '0) && (chunk_id <= nc_eff);

	// scan stage 1: row data back from RAM
	assign hit = scan_vld_s1 && user_active_q[idx_s1] && ram_rdata[bit_idx_q];

	// sequencer
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		pend_vld_d = pend_vld_q;
		pend_d     = pend_q;
		emit       = 1'b0;
		e_status   = ST_EMPTY;
		e_user     = '0;
		e_last     = 1'b1;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		act_idx    = idx_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = join_row_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_JOIN: begin
							state_d = S_JOIN;
							idx_d   = '0;
						end
						OP_LEAVE: begin
							if (uid_ok) begin
								act_clr = 1'b1;
								act_idx = slot_in;
							end
						end
						OP_REQUEST: begin
							if (uid_ok && cid_ok) begin
								state_d    = S_SCAN;
								idx_d      = '0;
								pend_vld_d = 1'b0;
							end else begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_JOIN: begin
				if (!user_active_q[idx_q]) begin
					act_set  = 1'b1;
					ram_we   = 1'b1;
					emit     = 1'b1;
					e_status = ST_JOIN_OK;
					e_user   = UID_W'(7'(idx_q) + 7'd1);
					state_d  = S_IDLE;
				end else if (idx_q == LAST_IDX) begin
					emit     = 1'b1;
					e_status = ST_FULL;
					state_d  = S_IDLE;
				end else begin
					idx_d = idx_q + UIDX_W'(1);
				end
			end
			S_SCAN: begin
				ram_re = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end else begin
					idx_d = idx_q + UIDX_W'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				emit = 1'b1;
				if (pend_vld_q) begin
					e_status  = ST_OWNER;
					e_user    = UID_W'(7'(pend_q) + 7'd1);
					ram_we    = 1'b1;
					ram_waddr = slot_q;
					ram_wdata = row_q | (MAX_CHUNKS'(1) << bit_idx_q);
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// owner found: send the one held back, hold this one (last mark unknown yet)
		if (hit) begin
			if (pend_vld_q) begin
				emit     = 1'b1;
				e_status = ST_OWNER;
				e_user   = UID_W'(7'(pend_q) + 7'd1);
				e_last   = 1'b0;
			end
			pend_vld_d = 1'b1;
			pend_d     = idx_s1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			user_active_q <= '0;
			num_chunks_q  <= NUM_CHUNKS_RST;
			idx_q         <= '0;
			scan_vld_s1   <= 1'b0;
			pend_vld_q    <= 1'b0;
			res_vld_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			scan_vld_s1 <= ram_re;
			pend_vld_q  <= pend_vld_d;
			res_vld_q   <= emit;
			if (act_set) begin
				user_active_q[act_idx] <= 1'b1;
			end
			if (act_clr) begin
				user_active_q[act_idx] <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				num_chunks_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		pend_q <= pend_d;
		if (accept) begin
			slot_q     <= slot_in;
			bit_idx_q  <= CIDX_W'(chunk_id - CID_W'(1));
			join_row_q <= owned_mask[MAX_CHUNKS-1:0] & chunk_mask;
		end
		// keep the requester's own row for the final update
		if (scan_vld_s1 && (idx_s1 == slot_q)) begin
			row_q <= ram_rdata;
		end
		if (emit) begin
			res_status_q <= e_status;
			res_user_q   <= e_user;
			res_last_q   <= e_last;
		end
	end

	assign result_valid = res_vld_q;
	assign status       = res_status_q;
	assign result_user  = res_user_q;
	assign is_last      = res_last_q;

	// ownership rows, one per user slot
	csd_ram #(
		.WIDTH (MAX_CHUNKS),
		.DEPTH (MAX_USERS),
		.AW    (UIDX_W)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/csd_checker.sv */
module csd_checker
	import csd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [OP_W-1:0]     op,
	input logic                result_valid,
	input logic [STATUS_W-1:0] status,
	input logic [UID_W-1:0]    result_user,
	input logic                is_last
);

	// a leave never produces a word
	a_leave_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_LEAVE) |=> !result_valid)
		else $error("leave produced a result");

	// join answers and no-owner answers stand alone
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == ST_JOIN_OK || status == ST_FULL || status == ST_EMPTY))
		|-> is_last)
		else $error("single-word answer without last mark");

	// full and no-owner answers carry no user
	a_zero_user: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == ST_FULL || status == ST_EMPTY)) |-> (result_user == '0))
		else $error("nonzero user on empty answer");

	// more owners pending: the block is still scanning
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !is_last) |-> busy)
		else $error("non-last owner word while idle");

endmodule

bind chunk_sharer_directory_top csd_checker u_csd_checker (.*);
